/* sv/xxtea_block_cipher_64_macros.svh */
// Assertion macros shared by the XXTEA cipher modules.
`ifndef XXTEA_BLOCK_CIPHER_64_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_64_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define XXTEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xxtea assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define XXTEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xxtea assertion failed");

`endif

/* sv/xxtea_pkg.sv */
// Types, constants and helpers shared by the XXTEA cipher modules.
package xxtea_pkg;

  localparam int unsigned Rounds    = 32;
  localparam int unsigned HalfSteps = 2 * Rounds;
  localparam logic [31:0] Delta     = 32'h9e37_79b9;
  localparam int unsigned AddrWidth = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] key_t;

  typedef struct packed {
    logic  valid;
    word_t w0;
    word_t w1;
  } blk_t;

  typedef struct packed {
    logic decrypt;
    key_t key;
  } cfg_t;

  // Running sum after 'count' additions of the round constant, mod 2^32.
  function automatic word_t sum_after(int unsigned count);
    logic [63:0] prod;
    prod = 64'(count) * 64'(Delta);
    return prod[31:0];
  endfunction

endpackage

/* sv/xxtea_regs.sv */
// APB-style configuration registers: mode bit and four key words.
module xxtea_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [xxtea_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output xxtea_pkg::cfg_t                   cfg_o
);
  import xxtea_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE: cfg_d.decrypt = pwdata[0];
        REG_KEY0: cfg_d.key[0]  = pwdata;
        REG_KEY1: cfg_d.key[1]  = pwdata;
        REG_KEY2: cfg_d.key[2]  = pwdata;
        REG_KEY3: cfg_d.key[3]  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE: prdata = {31'b0, cfg_q.decrypt};
      REG_KEY0: prdata = cfg_q.key[0];
      REG_KEY1: prdata = cfg_q.key[1];
      REG_KEY2: prdata = cfg_q.key[2];
      REG_KEY3: prdata = cfg_q.key[3];
      default:  prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  `include "xxtea_block_cipher_64_macros.svh"

  `XXTEA_ASSERT_NXT(a_mode_write, wr_en && (reg_idx == REG_MODE), cfg_q.decrypt == $past(pwdata[0]))
  `XXTEA_ASSERT_NXT(a_no_write_holds, !wr_en, cfg_q == $past(cfg_q))
  `XXTEA_ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

/* sv/xxtea_cell.sv */
// One half-round cell: update one block word by the XXTEA mix, register the block.
module xxtea_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xxtea_pkg::blk_t     blk_i,
  input  xxtea_pkg::word_t    sum_i,
  input  logic                sel_i,      // word index p being updated
  input  logic                decrypt_i,
  input  xxtea_pkg::key_t     key_i,
  output xxtea_pkg::blk_t     blk_o
);
  import xxtea_pkg::*;

  word_t      other, target, mix_a, mix_b, mix_v, updated;
  logic [1:0] key_idx;
  logic       valid_q;
  word_t      w0_q, w1_q;

  assign other   = sel_i ? blk_i.w0 : blk_i.w1;
  assign target  = sel_i ? blk_i.w1 : blk_i.w0;
  assign key_idx = {1'b0, sel_i} ^ sum_i[3:2];
  assign mix_a   = ((other >> 5) ^ (other << 2)) + ((other >> 3) ^ (other << 4));
  assign mix_b   = (sum_i ^ other) + (key_i[key_idx] ^ other);
  assign mix_v   = mix_a ^ mix_b;
  assign updated = decrypt_i ? (target - mix_v) : (target + mix_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= blk_i.valid;
    end
  end

  // Payload needs no reset; advance it every cycle.
  always_ff @(posedge clk_i) begin
    w0_q <= sel_i ? blk_i.w0 : updated;
    w1_q <= sel_i ? updated : blk_i.w1;
  end

  assign blk_o = '{valid: valid_q, w0: w0_q, w1: w1_q};

  `include "xxtea_block_cipher_64_macros.svh"

  `XXTEA_ASSERT_NXT(a_valid_moves, blk_i.valid, valid_q)
  `XXTEA_ASSERT_NXT(a_other_word_kept, blk_i.valid && !sel_i, w1_q == $past(blk_i.w1))
  `XXTEA_ASSERT_NXT(a_other_word_kept1, blk_i.valid && sel_i, w0_q == $past(blk_i.w0))

endmodule

/* sv/xxtea_block_cipher_64.sv */
// Top level of the XXTEA 64-bit block cipher: config port and a 64-cell half-round chain.
// Pipeline: a block accepted at one clock edge passes through one register per half-round
//   cell (two cells per round, 32 rounds) and then leaves on done_o.
// Throughput: one block per cycle; busy stays low and every cell advances each cycle.
// Reset (rst_ni low, asynchronous): clears all valid bits in the chain, the mode bit and
//   the key words; blocks in flight are dropped. Results cannot be stalled by the receiver.
module xxtea_block_cipher_64 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       first_word_i,
  input  logic [31:0]                       second_word_i,
  // result channel: one beat per cycle, marked by done_o
  output logic                              done_o,
  output logic [31:0]                       result_first_o,
  output logic [31:0]                       result_second_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [xxtea_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import xxtea_pkg::*;

  cfg_t cfg;
  blk_t chain [HalfSteps+1];

  xxtea_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The chain never stalls, so a new command beat is taken every cycle.
  assign busy = 1'b0;

  // Feed the head of the chain straight from the command ports.
  assign chain[0] = '{valid: start && !busy, w0: first_word_i, w1: second_word_i};

  // Cell k performs half of round k/2. Encryption walks the rounds forward with the
  // sum growing from Delta and updates word 0 then word 1; decryption walks them
  // backward from 32*Delta and updates word 1 then word 0, subtracting the mix.
  // User must change config only with the chain empty (unenforced); cells read it directly.
  for (genvar k = 0; k < HalfSteps; k++) begin : g_cell
    localparam int unsigned RoundIdx = k / 2;
    localparam word_t       SumEnc   = sum_after(RoundIdx + 1);
    localparam word_t       SumDec   = sum_after(Rounds - RoundIdx);
    localparam logic        SelEnc   = 1'(k % 2);

    word_t sum;
    logic  sel;

    assign sum = cfg.decrypt ? SumDec : SumEnc;
    assign sel = cfg.decrypt ? !SelEnc : SelEnc;

    xxtea_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .blk_i     (chain[k]),
      .sum_i     (sum),
      .sel_i     (sel),
      .decrypt_i (cfg.decrypt),
      .key_i     (cfg.key),
      .blk_o     (chain[k+1])
    );
  end

  // The last cell's register is the output register; hold each beat for one cycle.
  assign done_o          = chain[HalfSteps].valid;
  assign result_first_o  = chain[HalfSteps].w0;
  assign result_second_o = chain[HalfSteps].w1;

endmodule
